// ===== rtl/core/rse_pkg.sv =====
// Shared constants, types and helpers for the Roberts/Sobel edge magnitude block.
`default_nettype none

package rse_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int MAX_COLS_DEF   = 1024;
	localparam int MAX_ROWS_DEF   = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_COLS = 2'd1,
		REG_ROWS = 2'd2
	} reg_idx_t;

	// Register reset values
	localparam int COLS_RESET = 1024;
	localparam int ROWS_RESET = 1024;

	// Mask set select
	localparam logic MODE_ROBERTS = 1'b0;
	localparam logic MODE_SOBEL   = 1'b1;

	// Input command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Result width and saturation limit
	localparam int MAG_W = 12;
	localparam logic [MAG_W-1:0] MAG_MAX = 12'd4095;

	// Mask coefficients: vertical, horizontal, right diagonal, left diagonal
	typedef logic signed [2:0] coef_t;

	localparam coef_t ROB_K [4][2][2] = '{
		'{'{ 3'sd1, -3'sd1}, '{ 3'sd1, -3'sd1}},
		'{'{ 3'sd1,  3'sd1}, '{-3'sd1, -3'sd1}},
		'{'{ 3'sd1, -3'sd1}, '{-3'sd1,  3'sd1}},
		'{'{-3'sd1,  3'sd1}, '{ 3'sd1, -3'sd1}}
	};

	localparam coef_t SOB_K [4][3][3] = '{
		'{'{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd2,  3'sd0, -3'sd2}, '{ 3'sd1,  3'sd0, -3'sd1}},
		'{'{ 3'sd1,  3'sd2,  3'sd1}, '{ 3'sd0,  3'sd0,  3'sd0}, '{-3'sd1, -3'sd2, -3'sd1}},
		'{'{ 3'sd2,  3'sd1,  3'sd0}, '{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd0, -3'sd1, -3'sd2}},
		'{'{ 3'sd0,  3'sd1,  3'sd2}, '{-3'sd1,  3'sd0,  3'sd1}, '{-3'sd2, -3'sd1,  3'sd0}}
	};

	// Window control handed from the sequencer to the window stage
	typedef struct packed {
		logic       bypass;     // bottom of the right column is the incoming pixel
		logic       first_col;  // left column replicates the center column
		logic       last;       // result is the frame's final pixel
		logic [1:0] slot_up;    // line slot of the row above (clamped)
		logic [1:0] slot_mid;   // line slot of the center row
		logic [1:0] slot_dn;    // line slot of the row below (clamped)
	} win_ctl_t;

	// Line slots rotate through three rows
	function automatic logic [1:0] slot_next(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic logic [1:0] slot_prev(input logic [1:0] s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rse_pix_if.sv =====
// Pixel input channel: valid/ready handshake with command and pixel payload.
`default_nettype none

interface rse_pix_if
	import rse_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output command, output pixel_value, input ready);
	modport sink (input valid, input command, input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rse_mag_if.sv =====
// Result channel: valid/ready handshake with edge magnitude and frame-end flag.
`default_nettype none

interface rse_mag_if
	import rse_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] edge_magnitude;
	logic             frame_last;

	modport source (output valid, output edge_magnitude, output frame_last, input ready);
	modport sink (input valid, input edge_magnitude, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rse_ctrl.sv =====
// Configuration registers and raster sequencer: input/output positions and line addressing.
`default_nettype none

module rse_ctrl
	import rse_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	localparam int COL_W = $clog2(MAX_COLS),
	localparam int ROW_W = $clog2(MAX_ROWS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 acc,
	input  logic                 command,
	output logic                 mode,
	output logic                 produce,
	output logic                 wr_en,
	output logic [1:0]           wr_slot,
	output logic [COL_W-1:0]     wr_addr,
	output logic [COL_W-1:0]     rd_addr_a,
	output logic [COL_W-1:0]     rd_addr_b,
	output win_ctl_t             ctl
);

	localparam int COLS_RST_EFF = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
	localparam int ROWS_RST_EFF = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

	logic             mode_q;
	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [1:0]       in_slot_q;
	logic             in_done_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic [1:0]       out_slot_q;

	logic [31:0]      cfg_val;
	logic [COL_W-1:0] col_last_new;
	logic [ROW_W-1:0] row_last_new;
	logic             restart;
	logic             pix_take;
	logic             pix_out;
	logic             drain_out;
	logic             out_end;
	logic             last;

	// Clamp written sizes into 1..MAX, kept as last index
	always_comb begin
		cfg_val = 32'(cfg_data);
		if (cfg_val == 32'd0) begin
			col_last_new = '0;
			row_last_new = '0;
		end else begin
			if (cfg_val > 32'(MAX_COLS)) begin
				col_last_new = COL_W'(MAX_COLS - 1);
			end else begin
				col_last_new = COL_W'(cfg_val - 32'd1);
			end
			if (cfg_val > 32'(MAX_ROWS)) begin
				row_last_new = ROW_W'(MAX_ROWS - 1);
			end else begin
				row_last_new = ROW_W'(cfg_val - 32'd1);
			end
		end
	end

	assign restart = cfg_en && (cfg_addr == REG_COLS || cfg_addr == REG_ROWS);

	// Decide what the offered item does
	always_comb begin
		pix_take  = (command == CMD_PIXEL) && !in_done_q;
		pix_out   = pix_take && ((in_row_q > ROW_W'(1)) ||
		            (in_row_q == ROW_W'(1) && in_col_q != '0));
		drain_out = (command == CMD_DRAIN) && in_done_q;
		out_end   = (out_row_q == row_last_q) && (out_col_q == col_last_q);
		last      = drain_out && out_end;
		produce   = pix_out || drain_out;
	end

	// Line store addressing for the result position
	always_comb begin
		wr_en     = acc && pix_take;
		wr_slot   = in_slot_q;
		wr_addr   = in_col_q;
		rd_addr_b = out_col_q;
		rd_addr_a = (out_col_q == col_last_q) ? out_col_q : out_col_q + COL_W'(1);

		ctl.bypass    = pix_out && (in_col_q != '0);
		ctl.first_col = (out_col_q == '0);
		ctl.last      = last;
		ctl.slot_mid  = out_slot_q;
		ctl.slot_up   = (out_row_q == '0) ? out_slot_q : slot_prev(out_slot_q);
		ctl.slot_dn   = (out_row_q == row_last_q) ? out_slot_q : slot_next(out_slot_q);
	end

	assign mode = mode_q;

	// Hold configuration and advance positions on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SOBEL;
			col_last_q <= COL_W'(COLS_RST_EFF - 1);
			row_last_q <= ROW_W'(ROWS_RST_EFF - 1);
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= 2'd0;
			in_done_q  <= 1'b0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= 2'd0;
		end else begin
			if (cfg_en) begin
				unique case (cfg_addr)
					REG_MODE: mode_q     <= cfg_data[0];
					REG_COLS: col_last_q <= col_last_new;
					REG_ROWS: row_last_q <= row_last_new;
					default: ;
				endcase
			end

			if (restart || (acc && last)) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_slot_q  <= 2'd0;
				in_done_q  <= 1'b0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= 2'd0;
			end else if (acc) begin
				// advance input position
				if (pix_take) begin
					if (in_col_q == col_last_q) begin
						in_col_q <= '0;
						if (in_row_q == row_last_q) begin
							in_done_q <= 1'b1;
						end else begin
							in_row_q  <= in_row_q + ROW_W'(1);
							in_slot_q <= slot_next(in_slot_q);
						end
					end else begin
						in_col_q <= in_col_q + COL_W'(1);
					end
				end
				// advance output position
				if (produce) begin
					if (out_col_q == col_last_q) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + ROW_W'(1);
						out_slot_q <= slot_next(out_slot_q);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rse_line_store.sv =====
// Three-row line store: one bank per row slot, one write and two registered reads.
`default_nettype none

module rse_line_store
	import rse_pkg::*;
#(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int COL_W = $clog2(MAX_COLS)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [1:0]            wr_slot,
	input  logic [COL_W-1:0]      wr_addr,
	input  logic [PIXEL_BITS-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [COL_W-1:0]      rd_addr_a,
	input  logic [COL_W-1:0]      rd_addr_b,
	output logic [PIXEL_BITS-1:0] col_a [3],
	output logic [PIXEL_BITS-1:0] col_b [3]
);

	for (genvar g = 0; g < 3; g++) begin : g_bank
		logic [PIXEL_BITS-1:0] mem [MAX_COLS];

		// Write the incoming pixel; reads return the contents before this write
		always_ff @(posedge clk) begin
			if (wr_en && wr_slot == 2'(g)) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				col_a[g] <= mem[rd_addr_a];
				col_b[g] <= mem[rd_addr_b];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rse_edge_calc.sv =====
// Window assembly and four-mask magnitude with saturation.
`default_nettype none

module rse_edge_calc
	import rse_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  mode,
	input  logic                  adv,
	input  win_ctl_t              ctl,
	input  logic [PIXEL_BITS-1:0] pix,
	input  logic [PIXEL_BITS-1:0] col_a [3],
	input  logic [PIXEL_BITS-1:0] col_b [3],
	output logic [MAG_W-1:0]      magnitude
);

	localparam int RESP_W = PIXEL_BITS + 4;
	localparam int SUM_W  = PIXEL_BITS + 5;
	localparam int CMP_W  = (SUM_W > MAG_W) ? SUM_W : MAG_W;

	logic [1:0]               slot [3];
	logic [PIXEL_BITS-1:0]    w [3][3];
	logic [PIXEL_BITS-1:0]    prev_q [3];
	logic signed [RESP_W-1:0] resp [4];
	logic [SUM_W-1:0]         abs_r [4];
	logic [SUM_W-1:0]         total;
	logic [CMP_W-1:0]         total_w;

	assign slot[0] = ctl.slot_up;
	assign slot[1] = ctl.slot_mid;
	assign slot[2] = ctl.slot_dn;

	// Build the 3x3 window: rows up/mid/down, columns left/center/right
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			w[a][2] = col_a[slot[a]];
			w[a][1] = col_b[slot[a]];
			w[a][0] = ctl.first_col ? col_b[slot[a]] : prev_q[a];
		end
		if (ctl.bypass) begin
			w[2][2] = pix;
		end
	end

	// Keep the center column as the next result's left column
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				prev_q[a] <= w[a][1];
			end
		end
	end

	// Apply the four masks and sum their absolute responses
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			resp[k] = '0;
			if (mode == MODE_ROBERTS) begin
				for (int a = 0; a < 2; a++) begin
					for (int b = 0; b < 2; b++) begin
						resp[k] = resp[k] + RESP_W'($signed({1'b0, w[a+1][b+1]})) *
						          RESP_W'(ROB_K[k][a][b]);
					end
				end
			end else begin
				for (int a = 0; a < 3; a++) begin
					for (int b = 0; b < 3; b++) begin
						resp[k] = resp[k] + RESP_W'($signed({1'b0, w[a][b]})) *
						          RESP_W'(SOB_K[k][a][b]);
					end
				end
			end
			abs_r[k] = resp[k][RESP_W-1] ? SUM_W'(-resp[k]) : SUM_W'(resp[k]);
		end
		total   = abs_r[0] + abs_r[1] + abs_r[2] + abs_r[3];
		total_w = CMP_W'(total);
		magnitude = (total_w > CMP_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(total_w);
	end

endmodule

`default_nettype wire

// ===== rtl/core/roberts_sobel_edge_magnitude.sv =====
// The item that causes a result is registered in the window stage, then in the result register.
// Throughput: one item per cycle unless mag stalls; line store reads a column pair as it writes.
// A result belongs to the pixel cols+1 pixel transfers earlier; drain items flush the rest.
// Reset: mode Sobel, cols and rows 1024 (limited to the maximum), positions cleared.
// The line store is not cleared; every entry is written before it is read.
`default_nettype none

module roberts_sobel_edge_magnitude
	import rse_pkg::*;
#(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data,
	rse_pix_if.sink              pix,
	rse_mag_if.source            mag
);

	localparam int COL_W = $clog2(MAX_COLS);

	logic                  acc;
	logic                  produce;
	logic                  mode;
	logic                  wr_en;
	logic [1:0]            wr_slot;
	logic [COL_W-1:0]      wr_addr;
	logic [COL_W-1:0]      rd_addr_a;
	logic [COL_W-1:0]      rd_addr_b;
	win_ctl_t              ctl_s0;
	win_ctl_t              ctl_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] col_a [3];
	logic [PIXEL_BITS-1:0] col_b [3];
	logic [MAG_W-1:0]      mag_comb;
	logic                  valid_s2;
	logic [MAG_W-1:0]      mag_s2;
	logic                  last_s2;
	logic                  adv_s1;
	logic                  adv_s2;

	// Handshake: the result register frees the window stage, which frees the input
	assign adv_s2    = !valid_s2 || mag.ready;
	assign adv_s1    = valid_s1 && adv_s2;
	assign pix.ready = !valid_s1 || adv_s2;
	assign acc       = pix.valid && pix.ready;

	rse_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.command   (pix.command),
		.mode      (mode),
		.produce   (produce),
		.wr_en     (wr_en),
		.wr_slot   (wr_slot),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.ctl       (ctl_s0)
	);

	rse_line_store #(
		.MAX_COLS   (MAX_COLS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_slot   (wr_slot),
		.wr_addr   (wr_addr),
		.wr_data   (pix.pixel_value),
		.rd_en     (acc && produce),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.col_a     (col_a),
		.col_b     (col_b)
	);

	// Capture window control and the incoming pixel next to the line reads
	always_ff @(posedge clk) begin
		if (acc && produce) begin
			ctl_s1 <= ctl_s0;
			pix_s1 <= pix.pixel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= acc && produce;
		end
	end

	rse_edge_calc #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_edge_calc (
		.clk       (clk),
		.mode      (mode),
		.adv       (adv_s1),
		.ctl       (ctl_s1),
		.pix       (pix_s1),
		.col_a     (col_a),
		.col_b     (col_b),
		.magnitude (mag_comb)
	);

	// Result register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mag_s2  <= mag_comb;
			last_s2 <= ctl_s1.last;
		end
	end

	assign mag.valid          = valid_s2;
	assign mag.edge_magnitude = mag_s2;
	assign mag.frame_last     = last_s2;

endmodule

`default_nettype wire
